### rtl/mrx_pkg.sv
// Shared types and constants for the marker synced RGB frame receiver.
// No dependencies; used by mrx_skid and marker_synced_rgb_frame_receiver.
package mrx_pkg;

    // Configuration port layout
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MARKER_FIRST  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MARKER_SECOND = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MARKER_THIRD  = 3'd4;

    // Field widths
    localparam int SIZE_W  = 7;
    localparam int BYTE_W  = 8;
    localparam int COORD_W = 6;
    localparam int COUNT_W = 32;

    // Stream data widths
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 72;

    // One pixel result on its way to the output port
    typedef struct packed {
        logic [COUNT_W-1:0] frames_done;
        logic               frame_end;
        logic [BYTE_W-1:0]  blue;
        logic [BYTE_W-1:0]  green;
        logic [BYTE_W-1:0]  red;
        logic [COORD_W-1:0] pixel_row;
        logic [COORD_W-1:0] pixel_column;
    } pix_t;

endpackage

### rtl/mrx_skid.sv
// Output register with a skid stage for pixel words.
// Depends on mrx_pkg for the pix_t word type.
module mrx_skid
    import mrx_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  pix_t in_word,
    output logic out_valid,
    input  logic out_ready,
    output pix_t out_word
);

    logic main_valid_reg;
    logic skid_valid_reg;
    pix_t main_word_reg;
    pix_t skid_word_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_word  = main_word_reg;

    // Control: refill the output register, park a word in the skid stage on a stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= in_valid;
            end
        end
        else if (in_valid && !skid_valid_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload: no reset
    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || out_ready)
        begin
            main_word_reg <= skid_valid_reg ? skid_word_reg : in_word;
        end
        else if (in_valid && !skid_valid_reg)
        begin
            skid_word_reg <= in_word;
        end
    end

endmodule

### rtl/marker_synced_rgb_frame_receiver.sv
// Top level of the marker synced RGB frame receiver: marker hunt, pixel assembly,
// raster counters and frame count. Depends on mrx_pkg and mrx_skid.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata: rx_byte
//  m_*      out  m_tvalid/m_tready  m_tdata: pixel fields, m_tlast: frame_end
//  cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One serial byte per cycle while s_tready is high; each byte is handled in the cycle
// it is taken, and a pixel is registered into mrx_skid when its blue byte is taken.
// The output register plus skid stage hold up to two pixels, so s_tready
// drops only when both are full, which follows a stalled m_tready.
// Reset leaves the block hunting with a cleared marker window and size 16x16.
// cfg_ready is always high.
module marker_synced_rgb_frame_receiver
    import mrx_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // rx_byte [7:0]
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,
    // pixel_column [5:0], pixel_row [11:6], red [19:12], green [27:20],
    // blue [35:28], frames_done [67:36], zero [71:68]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW   = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CCMP = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
    localparam int RCMP = (RW + 1 > SIZE_W) ? RW + 1 : SIZE_W;
    localparam int CXW  = (CW > COORD_W) ? CW : COORD_W;
    localparam int RXW  = (RW > COORD_W) ? RW : COORD_W;

    // Color phase codes
    localparam logic [1:0] PH_RED   = 2'd0;
    localparam logic [1:0] PH_GREEN = 2'd1;
    localparam logic [1:0] PH_BLUE  = 2'd2;

    logic [SIZE_W-1:0]  width_cfg_reg;
    logic [SIZE_W-1:0]  height_cfg_reg;
    logic [BYTE_W-1:0]  marker0_reg;
    logic [BYTE_W-1:0]  marker1_reg;
    logic [BYTE_W-1:0]  marker2_reg;

    logic               hunting_reg;
    logic [BYTE_W-1:0]  win1_reg;
    logic [BYTE_W-1:0]  win2_reg;
    logic [1:0]         phase_reg;
    logic [BYTE_W-1:0]  red_reg;
    logic [BYTE_W-1:0]  green_reg;
    logic [CW-1:0]      column_reg;
    logic [RW-1:0]      row_reg;
    logic [COUNT_W-1:0] frames_reg;

    logic               take;
    logic [BYTE_W-1:0]  rx_byte;
    logic               marker_hit;
    logic [CCMP-1:0]    width_ext;
    logic [CCMP-1:0]    width_use;
    logic [RCMP-1:0]    height_ext;
    logic [RCMP-1:0]    height_use;
    logic               row_done;
    logic               last_pixel;
    logic [COUNT_W-1:0] frames_next;
    logic [CXW-1:0]     column_wide;
    logic [RXW-1:0]     row_wide;
    logic               pix_valid;
    logic               pix_ready;
    pix_t               pix_word;
    pix_t               out_word;

    assign rx_byte   = s_tdata[BYTE_W-1:0];
    assign s_tready  = pix_ready;
    assign take      = s_tvalid && pix_ready;
    assign cfg_ready = 1'b1;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= SIZE_W'(16);
            height_cfg_reg <= SIZE_W'(16);
            marker0_reg    <= '0;
            marker1_reg    <= '0;
            marker2_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:   width_cfg_reg  <= cfg_data[SIZE_W-1:0];
                REG_FRAME_HEIGHT:  height_cfg_reg <= cfg_data[SIZE_W-1:0];
                REG_MARKER_FIRST:  marker0_reg    <= cfg_data;
                REG_MARKER_SECOND: marker1_reg    <= cfg_data;
                REG_MARKER_THIRD:  marker2_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Clamp the frame size into 1..MAX
    always_comb
    begin
        width_ext  = CCMP'(width_cfg_reg);
        height_ext = RCMP'(height_cfg_reg);
        if (width_ext == '0)
            width_use = CCMP'(1);
        else if (width_ext > CCMP'(MAX_WIDTH))
            width_use = CCMP'(MAX_WIDTH);
        else
            width_use = width_ext;
        if (height_ext == '0)
            height_use = RCMP'(1);
        else if (height_ext > RCMP'(MAX_HEIGHT))
            height_use = RCMP'(MAX_HEIGHT);
        else
            height_use = height_ext;
    end

    // Marker match on the shifted window, raster end tests
    assign marker_hit  = (win1_reg == marker0_reg) && (win2_reg == marker1_reg)
                         && (rx_byte == marker2_reg);
    assign row_done    = (CCMP'(column_reg) + CCMP'(1)) >= width_use;
    assign last_pixel  = row_done && ((RCMP'(row_reg) + RCMP'(1)) >= height_use);
    assign frames_next = frames_reg + COUNT_W'(1);

    // Hunt and pixel assembly state; the oldest window byte drops out after the compare
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunting_reg <= 1'b1;
            win1_reg    <= '0;
            win2_reg    <= '0;
            phase_reg   <= PH_RED;
            column_reg  <= '0;
            row_reg     <= '0;
            frames_reg  <= '0;
        end
        else if (take)
        begin
            if (hunting_reg)
            begin
                win1_reg <= win2_reg;
                win2_reg <= rx_byte;
                if (marker_hit)
                begin
                    hunting_reg <= 1'b0;
                    phase_reg   <= PH_RED;
                    column_reg  <= '0;
                    row_reg     <= '0;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_RED:   phase_reg <= PH_GREEN;
                    PH_GREEN: phase_reg <= PH_BLUE;
                    default:
                    begin
                        phase_reg <= PH_RED;
                        if (last_pixel)
                        begin
                            frames_reg  <= frames_next;
                            hunting_reg <= 1'b1;
                            column_reg  <= '0;
                            row_reg     <= '0;
                        end
                        else if (row_done)
                        begin
                            column_reg <= '0;
                            row_reg    <= row_reg + RW'(1);
                        end
                        else
                        begin
                            column_reg <= column_reg + CW'(1);
                        end
                    end
                endcase
            end
        end
    end

    // Hold red and green until the blue byte arrives
    always_ff @(posedge clk)
    begin
        if (take && !hunting_reg)
        begin
            if (phase_reg == PH_RED)
                red_reg <= rx_byte;
            if (phase_reg == PH_GREEN)
                green_reg <= rx_byte;
        end
    end

    // Build the pixel word
    assign column_wide = CXW'(column_reg);
    assign row_wide    = RXW'(row_reg);
    assign pix_valid   = take && !hunting_reg && (phase_reg != PH_RED)
                         && (phase_reg != PH_GREEN);

    always_comb
    begin
        pix_word.pixel_column = column_wide[COORD_W-1:0];
        pix_word.pixel_row    = row_wide[COORD_W-1:0];
        pix_word.red          = red_reg;
        pix_word.green        = green_reg;
        pix_word.blue         = rx_byte;
        pix_word.frame_end    = last_pixel;
        pix_word.frames_done  = last_pixel ? frames_next : '0;
    end

    mrx_skid u_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix_valid),
        .in_ready  (pix_ready),
        .in_word   (pix_word),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    // Pack the output word
    assign m_tdata = {4'b0000, out_word.frames_done, out_word.blue, out_word.green,
                      out_word.red, out_word.pixel_row, out_word.pixel_column};
    assign m_tlast = out_word.frame_end;

endmodule
